// ----- src/snf_pkg.sv -----
// Package for the fractal simplex noise block: fixed-point constants,
// the permutation ROM and the gradient table. No dependencies.
`default_nettype none
package snf_pkg;

   localparam int AccW      = 48;
   localparam int GradCount = 12;
   localparam int OffW      = 20;

   localparam logic signed [16:0] SkewF    = 17'sd23988;
   localparam logic signed [16:0] UnskewG  = 17'sd13849;
   localparam logic signed [16:0] UnskewG2 = 17'sd27698;
   localparam logic signed [17:0] OneQ16   = 18'sd65536;
   localparam logic signed [16:0] HalfQ16  = 17'sd32768;

   localparam logic [7:0] PermTable [256] = '{
      8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
      8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
      8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
      8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
      8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
      8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
      8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,
      8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
      8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,
      8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
      8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,
      8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
      8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
      8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
      8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,
      8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
      8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,
      8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
      8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,
      8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
      8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
      8'd215,8'd61,8'd156,8'd180
   };

   function automatic logic [7:0] perm_at(input logic [7:0] idx);
      return PermTable[idx];
   endfunction

   // Gradient index of a hashed corner: the ROM entry modulo twelve, found by
   // subtracting multiples of twelve from the largest down.
   function automatic logic [3:0] grad_at(input logic [7:0] idx);
      logic [7:0] v;
      v = PermTable[idx];
      for (int b = 4; b >= 0; b--) begin
         if (v >= 8'(GradCount << b)) begin
            v = v - 8'(GradCount << b);
         end
      end
      return v[3:0];
   endfunction

   // Gradient dot product with the corner offset; components are -1, 0 or 1.
   function automatic logic signed [OffW:0] grad_dot(input logic [3:0] g,
                                                      input logic signed [OffW-1:0] x,
                                                      input logic signed [OffW-1:0] y);
      logic signed [OffW:0] xe;
      logic signed [OffW:0] ye;
      xe = (OffW+1)'(x);
      ye = (OffW+1)'(y);
      case (g)
         4'd0:    return xe + ye;
         4'd1:    return ye - xe;
         4'd2:    return xe - ye;
         4'd3:    return -xe - ye;
         4'd4:    return xe;
         4'd5:    return -xe;
         4'd6:    return xe;
         4'd7:    return -xe;
         4'd8:    return ye;
         4'd9:    return -ye;
         4'd10:   return ye;
         4'd11:   return -ye;
         default: return '0;
      endcase
   endfunction

endpackage
`default_nettype wire

// ----- src/snf_ifs.sv -----
// Channel interfaces of the fractal simplex noise block: sample request
// and noise response. No dependencies.
`default_nettype none
interface snf_req_if ();
   logic                valid;
   logic                ready;
   logic signed [15:0]  x_coord;
   logic signed [15:0]  y_coord;
   modport source (output valid, output x_coord, output y_coord, input ready);
   modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

interface snf_rsp_if ();
   logic                valid;
   logic                ready;
   logic signed [15:0]  noise_value;
   modport source (output valid, output noise_value, input ready);
   modport sink   (input valid, input noise_value, output ready);
endinterface
`default_nettype wire

// ----- src/snf_prep.sv -----
// Front stage: turns an integer coordinate into round(c * 4096 / 5) in Q.16
// plus the remainder that the octave cells carry. Uses snf_pkg.
`default_nettype none
module snf_prep #(
   parameter int CW = 34
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic signed [15:0]    in_x,
   input  logic signed [15:0]    in_y,
   output logic                  out_valid,
   output logic signed [CW-1:0]  out_xq,
   output logic [2:0]            out_xr,
   output logic signed [CW-1:0]  out_yq,
   output logic [2:0]            out_yr
);
   import snf_pkg::*;

   logic                 v1_ff, v2_ff;
   logic signed [15:0]   c1_ff [2];
   logic [16:0]          u1_ff [2];
   logic [32:0]          p1_ff [2];
   logic signed [CW-1:0] q2_ff [2], q2_in [2];
   logic [2:0]           r2_ff [2], r2_in [2];
   logic [16:0]          u_in  [2];
   logic signed [15:0]   c_in  [2];

   assign c_in[0] = in_x;
   assign c_in[1] = in_y;

   // u = (c + 2) + 32770 is never negative, and 32770 is a multiple of five, so
   // the quotient gives round(c / 5) and the remainder is offset by two.
   always_comb begin
      for (int n = 0; n < 2; n++) begin
         u_in[n] = {1'b0, ~c_in[n][15], c_in[n][14:0]} + 17'd4;
      end
   end

   always_comb begin
      for (int n = 0; n < 2; n++) begin
         logic signed [18:0] q;
         logic signed [18:0] r;
         q = signed'({4'd0, p1_ff[n][32:18]});
         r = signed'({2'd0, u1_ff[n]}) - 19'sd5 * q;
         if (r >= 19'sd5) begin
            q = q + 19'sd1;
            r = r - 19'sd5;
         end else if (r < 19'sd0) begin
            q = q - 19'sd1;
            r = r + 19'sd5;
         end
         q2_in[n] = CW'(c1_ff[n]) * CW'(12'sd819) + CW'(q) - CW'(19'sd6554);
         r2_in[n] = r[2:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int n = 0; n < 2; n++) begin
            c1_ff[n] <= c_in[n];
            u1_ff[n] <= u_in[n];
            p1_ff[n] <= 33'(u_in[n]) * 33'd52429;
            q2_ff[n] <= q2_in[n];
            r2_ff[n] <= r2_in[n];
         end
      end
   end

   assign out_valid = v2_ff;
   assign out_xq    = q2_ff[0];
   assign out_xr    = r2_ff[0];
   assign out_yq    = q2_ff[1];
   assign out_yr    = r2_ff[1];

endmodule
`default_nettype wire

// ----- src/snf_octave_cell.sv -----
// One octave of 2D simplex noise as an eleven-stage pipeline; it adds its
// scaled share to the running sum and hands the doubled coordinate on.
// Uses snf_pkg.
`default_nettype none
module snf_octave_cell #(
   parameter int K  = 0,
   parameter int CW = 34
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        oct_on,
   input  logic                        in_valid,
   input  logic signed [CW-1:0]        in_xq,
   input  logic [2:0]                  in_xr,
   input  logic signed [CW-1:0]        in_yq,
   input  logic [2:0]                  in_yr,
   input  logic signed [snf_pkg::AccW-1:0] in_acc,
   output logic                        out_valid,
   output logic signed [CW-1:0]        out_xq,
   output logic [2:0]                  out_xr,
   output logic signed [CW-1:0]        out_yq,
   output logic [2:0]                  out_yr,
   output logic signed [snf_pkg::AccW-1:0] out_acc
);
   import snf_pkg::*;

   localparam int IW = CW - 14;
   localparam int FW = CW + 4;
   localparam int PW = CW + 18;
   localparam int BW = AccW + 2 * (CW + 3);
   localparam int NS = 10;

   // Running sum and next-octave coordinates ride along the stages.
   logic [BW-1:0]          bun_ff [NS];
   logic [NS-1:0]          val_ff;
   logic signed [CW-1:0]   nq_in [2];
   logic [2:0]             nr_in [2];

   logic signed [CW-1:0]   xq1_ff, yq1_ff;
   logic signed [PW-1:0]   prod1_ff;
   logic signed [IW-1:0]   i2_ff, j2_ff;
   logic signed [CW-1:0]   xq2_ff, yq2_ff;
   logic signed [OffW-1:0] x3_ff, y3_ff;
   logic [7:0]             ii3_ff, jj3_ff;
   logic signed [OffW-1:0] x4_ff [3], y4_ff [3];
   logic [7:0]             ii4_ff;
   logic                   i14_ff;
   logic [7:0]             p4_ff [3];
   logic signed [OffW-1:0] x5_ff [3], y5_ff [3];
   logic [3:0]             g5_ff [3];
   logic signed [39:0]     sx5_ff [3], sy5_ff [3];
   logic [15:0]            t6_ff [3];
   logic [2:0]             pos6_ff, pos7_ff, pos8_ff;
   logic signed [OffW:0]   dot6_ff [3], dot7_ff [3], dot8_ff [3];
   logic [31:0]            t27_ff [3];
   logic [31:0]            t48_ff [3];
   logic signed [50:0]     c9_ff [3];
   logic signed [52:0]     sum10_ff;

   logic                   out_valid_ff;
   logic signed [CW-1:0]   out_xq_ff, out_yq_ff;
   logic [2:0]             out_xr_ff, out_yr_ff;
   logic signed [AccW-1:0] out_acc_ff, out_acc_in;

   // Doubling rule for round(c * 2^(12+k) / 5) with remainder in 0..4.
   always_comb begin
      logic signed [CW-1:0] q [2];
      logic [2:0]           r [2];
      logic signed [4:0]    rr;
      q[0] = in_xq;
      q[1] = in_yq;
      r[0] = in_xr;
      r[1] = in_yr;
      for (int n = 0; n < 2; n++) begin
         rr = signed'({2'd0, r[n]}) * 5'sd2 - 5'sd2;
         nq_in[n] = q[n] <<< 1;
         if (rr < 5'sd0) begin
            nq_in[n] = nq_in[n] - CW'(2'sd1);
            nr_in[n] = 3'(rr + 5'sd5);
         end else if (rr >= 5'sd5) begin
            nq_in[n] = nq_in[n] + CW'(2'sd1);
            nr_in[n] = 3'(rr - 5'sd5);
         end else begin
            nr_in[n] = rr[2:0];
         end
      end
   end

   // Stage combinational logic.
   logic signed [PW-1:0]   xs_s1, ys_s1;
   logic signed [IW:0]     ij_s2;
   logic signed [FW-1:0]   t_s2, x0_s2, y0_s2;
   logic                   i1_s3;
   logic signed [OffW-1:0] x_s3 [3], y_s3 [3];
   logic [7:0]             p_s3 [3];
   logic [3:0]             g_s4 [3];
   logic signed [40:0]     d2_s5 [3];
   logic signed [25:0]     tt_s5 [3];
   logic signed [59:0]     m_s10;
   logic signed [43:0]     oct_s10;

   always_comb begin
      xs_s1 = PW'(xq1_ff) + (prod1_ff >>> 16);
      ys_s1 = PW'(yq1_ff) + (prod1_ff >>> 16);

      ij_s2 = (IW+1)'(i2_ff) + (IW+1)'(j2_ff);
      t_s2  = FW'(ij_s2) * FW'(UnskewG);
      x0_s2 = FW'(xq2_ff) - (FW'(i2_ff) <<< 16) + t_s2;
      y0_s2 = FW'(yq2_ff) - (FW'(j2_ff) <<< 16) + t_s2;

      i1_s3  = (x3_ff > y3_ff);
      x_s3[0] = x3_ff;
      y_s3[0] = y3_ff;
      x_s3[1] = x3_ff - (i1_s3 ? OffW'(OneQ16) : '0) + OffW'(UnskewG);
      y_s3[1] = y3_ff - (i1_s3 ? '0 : OffW'(OneQ16)) + OffW'(UnskewG);
      x_s3[2] = x3_ff - OffW'(OneQ16) + OffW'(UnskewG2);
      y_s3[2] = y3_ff - OffW'(OneQ16) + OffW'(UnskewG2);
      p_s3[0] = perm_at(jj3_ff);
      p_s3[1] = perm_at(8'(jj3_ff + {7'd0, ~i1_s3}));
      p_s3[2] = perm_at(8'(jj3_ff + 8'd1));

      g_s4[0] = grad_at(8'(ii4_ff + p4_ff[0]));
      g_s4[1] = grad_at(8'(ii4_ff + {7'd0, i14_ff} + p4_ff[1]));
      g_s4[2] = grad_at(8'(ii4_ff + 8'd1 + p4_ff[2]));

      for (int c = 0; c < 3; c++) begin
         d2_s5[c] = 41'(sx5_ff[c]) + 41'(sy5_ff[c]);
         tt_s5[c] = 26'(HalfQ16) - 26'(d2_s5[c] >>> 16);
      end

      m_s10   = (60'(sum10_ff) <<< 6) + (60'(sum10_ff) <<< 2) + (60'(sum10_ff) <<< 1);
      oct_s10 = 44'(m_s10 >>> 16) >>> (K + 1);
      out_acc_in = AccW'(bun_ff[NS-1][BW-1 -: AccW]);
      if (oct_on) begin
         out_acc_in = out_acc_in + AccW'(oct_s10);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         val_ff       <= {val_ff[NS-2:0], in_valid};
         out_valid_ff <= val_ff[NS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         bun_ff[0] <= {in_acc, nq_in[0], nr_in[0], nq_in[1], nr_in[1]};
         for (int s = 1; s < NS; s++) begin
            bun_ff[s] <= bun_ff[s-1];
         end

         xq1_ff   <= in_xq;
         yq1_ff   <= in_yq;
         prod1_ff <= PW'((CW+1)'(in_xq) + (CW+1)'(in_yq)) * PW'(SkewF);

         i2_ff  <= IW'(xs_s1 >>> 16);
         j2_ff  <= IW'(ys_s1 >>> 16);
         xq2_ff <= xq1_ff;
         yq2_ff <= yq1_ff;

         x3_ff  <= x0_s2[OffW-1:0];
         y3_ff  <= y0_s2[OffW-1:0];
         ii3_ff <= i2_ff[7:0];
         jj3_ff <= j2_ff[7:0];

         ii4_ff <= ii3_ff;
         i14_ff <= i1_s3;
         for (int c = 0; c < 3; c++) begin
            x4_ff[c] <= x_s3[c];
            y4_ff[c] <= y_s3[c];
            p4_ff[c] <= p_s3[c];

            x5_ff[c]  <= x4_ff[c];
            y5_ff[c]  <= y4_ff[c];
            g5_ff[c]  <= g_s4[c];
            sx5_ff[c] <= 40'(x4_ff[c]) * 40'(x4_ff[c]);
            sy5_ff[c] <= 40'(y4_ff[c]) * 40'(y4_ff[c]);

            // A corner on or beyond the falloff radius contributes nothing.
            pos6_ff[c] <= (tt_s5[c] > 26'sd0);
            t6_ff[c]   <= tt_s5[c][15:0];
            dot6_ff[c] <= grad_dot(g5_ff[c], x5_ff[c], y5_ff[c]);

            pos7_ff[c] <= pos6_ff[c];
            dot7_ff[c] <= dot6_ff[c];
            t27_ff[c]  <= 32'(t6_ff[c]) * 32'(t6_ff[c]);

            pos8_ff[c] <= pos7_ff[c];
            dot8_ff[c] <= dot7_ff[c];
            t48_ff[c]  <= 32'((64'(t27_ff[c]) * 64'(t27_ff[c])) >> 32);

            c9_ff[c] <= pos8_ff[c] ? signed'({1'b0, t48_ff[c][29:0]}) * 51'(dot8_ff[c])
                                   : '0;
         end

         sum10_ff <= 53'(c9_ff[0]) + 53'(c9_ff[1]) + 53'(c9_ff[2]);

         out_acc_ff <= out_acc_in;
         {out_xq_ff, out_xr_ff, out_yq_ff, out_yr_ff} <= bun_ff[NS-1][BW-AccW-1:0];
      end
   end

   assign out_valid = out_valid_ff;
   assign out_xq    = out_xq_ff;
   assign out_xr    = out_xr_ff;
   assign out_yq    = out_yq_ff;
   assign out_yr    = out_yr_ff;
   assign out_acc   = out_acc_ff;

endmodule
`default_nettype wire

// ----- src/simplex_noise_2d_fractal.sv -----
// Fractal 2D simplex noise: one noise sample per pixel coordinate beat.
// A beat enters every clock cycle while the response side takes results. A
// request passes through the two-stage coordinate front end, a chain of
// MAX_OCTAVES octave cells of eleven pipeline stages each, and the response
// register. A whole-chain stall is applied while a response waits. csr_wdata
// sets the octave count (zero acts as one, values above MAX_OCTAVES act as
// MAX_OCTAVES); write it only while no beat is in flight. Result is Q1.15,
// rounded and saturated.
`default_nettype none
module simplex_noise_2d_fractal #(
   parameter int MAX_OCTAVES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [3:0]  csr_wdata,
   snf_req_if.sink     req_beat,
   snf_rsp_if.source   rsp_beat
);
   import snf_pkg::*;

   localparam int CW = 26 + MAX_OCTAVES;

   logic                   en;
   logic [3:0]             oct_ff, oct_in;
   logic [4:0]             oct_eff;
   logic [MAX_OCTAVES-1:0] oct_on;

   logic                   lv [MAX_OCTAVES+1];
   logic signed [CW-1:0]   lxq [MAX_OCTAVES+1], lyq [MAX_OCTAVES+1];
   logic [2:0]             lxr [MAX_OCTAVES+1], lyr [MAX_OCTAVES+1];
   logic signed [AccW-1:0] lacc [MAX_OCTAVES+1];
   logic [MAX_OCTAVES:0]   lv_vec;

   logic                   rsp_valid_ff;
   logic signed [15:0]     rsp_noise_ff, rsp_noise_in;
   logic signed [AccW-1:0] rnd;

   assign en = !rsp_valid_ff || rsp_beat.ready;
   assign req_beat.ready = en;

   assign oct_in = csr_we ? csr_wdata : oct_ff;

   always_comb begin
      oct_eff = {1'b0, oct_ff};
      if (oct_eff == 5'd0) begin
         oct_eff = 5'd1;
      end else if (oct_eff > 5'(MAX_OCTAVES)) begin
         oct_eff = 5'(MAX_OCTAVES);
      end
      for (int k = 0; k < MAX_OCTAVES; k++) begin
         oct_on[k] = (5'(k) < oct_eff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oct_ff <= 4'd8;
      end else begin
         oct_ff <= oct_in;
      end
   end

   snf_prep #(.CW(CW)) u_prep (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_beat.valid),
      .in_x      (req_beat.x_coord),
      .in_y      (req_beat.y_coord),
      .out_valid (lv[0]),
      .out_xq    (lxq[0]),
      .out_xr    (lxr[0]),
      .out_yq    (lyq[0]),
      .out_yr    (lyr[0])
   );
   assign lacc[0] = '0;

   for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_cell
      snf_octave_cell #(.K(k), .CW(CW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .oct_on    (oct_on[k]),
         .in_valid  (lv[k]),
         .in_xq     (lxq[k]),
         .in_xr     (lxr[k]),
         .in_yq     (lyq[k]),
         .in_yr     (lyr[k]),
         .in_acc    (lacc[k]),
         .out_valid (lv[k+1]),
         .out_xq    (lxq[k+1]),
         .out_xr    (lxr[k+1]),
         .out_yq    (lyq[k+1]),
         .out_yr    (lyr[k+1]),
         .out_acc   (lacc[k+1])
      );
   end

   always_comb begin
      for (int k = 0; k <= MAX_OCTAVES; k++) begin
         lv_vec[k] = lv[k] ^ (lxr[k][0] & lyr[k][0] & 1'b0) ^ (lxq[k][0] & lyq[k][0] & 1'b0);
      end
   end

   // Round half up from Q.32 to Q.15, then clamp to the signed range.
   always_comb begin
      rnd = (lacc[MAX_OCTAVES] + AccW'(18'sd65536)) >>> 17;
      if (rnd > AccW'(17'sd32767)) begin
         rsp_noise_in = 16'sh7FFF;
      end else if (rnd < -AccW'(17'sd32768)) begin
         rsp_noise_in = -16'sh8000;
      end else begin
         rsp_noise_in = rnd[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= lv[MAX_OCTAVES];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_noise_ff <= rsp_noise_in;
      end
   end

   assign rsp_beat.valid       = rsp_valid_ff;
   assign rsp_beat.noise_value = rsp_noise_ff;

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_beat.valid)
      else $error("response valid after reset");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_beat.valid && !rsp_beat.ready |-> !req_beat.ready)
      else $error("request taken while response stalled");

   a_chain_frozen: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(lv_vec))
      else $error("cell chain moved during a stall");

endmodule
`default_nettype wire

// ----- dv/simplex_noise_2d_fractal_tb.sv -----
// Self-checking testbench for simplex_noise_2d_fractal: a queue-fed driver,
// a monitor that compares each noise beat with a built-in fixed-point model.
// Depends on snf_pkg, snf_ifs.sv and the block's RTL.
`timescale 1ns / 1ps
module simplex_noise_2d_fractal_tb;
   import snf_pkg::*;

   localparam int Latency = 3 + 11 * 8;
   localparam int WatchdogLimit = 20000;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
   } sample_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [3:0] csr_wdata = '0;

   snf_req_if req_beat ();
   snf_rsp_if rsp_beat ();

   simplex_noise_2d_fractal dut (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_beat(req_beat.sink), .rsp_beat(rsp_beat.source)
   );

   always #5 clock = ~clock;

   sample_type pending_samples[$];
   logic signed [15:0] expected_noise[$];
   logic [3:0] octave_setting = 4'd8;
   int mismatches = 0;
   int idle_cycles = 0;
   int burst_left = 0;
   int gap_left = 0;
   int stall_phase = 0;
   bit hold_sender = 1'b0;

   function automatic longint asr64(longint v, int n);
      return v >>> n;
   endfunction

   function automatic longint floor_div10(longint a);
      longint q;
      q = a / 10;
      if ((a % 10) != 0 && a < 0) q--;
      return q;
   endfunction

   function automatic longint falloff_term(int g, longint x, longint y);
      longint t;
      longint t2;
      longint t4;
      longint dot;
      longint gx;
      longint gy;
      t = 32768 - asr64(x * x + y * y, 16);
      if (t <= 0) return 0;
      t2 = t * t;
      t4 = asr64(t2 * t2, 32);
      case (g)
         0: begin gx = 1; gy = 1; end
         1: begin gx = -1; gy = 1; end
         2: begin gx = 1; gy = -1; end
         3: begin gx = -1; gy = -1; end
         4, 6: begin gx = 1; gy = 0; end
         5, 7: begin gx = -1; gy = 0; end
         8, 10: begin gx = 0; gy = 1; end
         default: begin gx = 0; gy = -1; end
      endcase
      dot = gx * x + gy * y;
      return t4 * dot;
   endfunction

   function automatic int hashed_grad(longint idx);
      return int'(PermTable[idx & 255]) % 12;
   endfunction

   function automatic longint octave_noise(longint xc, longint yc, int k);
      longint mul;
      longint xin;
      longint yin;
      longint s;
      longint i;
      longint j;
      longint t;
      longint x0;
      longint y0;
      longint x1;
      longint y1;
      longint x2;
      longint y2;
      longint i1;
      longint j1;
      longint ii;
      longint jj;
      longint sum;
      int g0;
      int g1;
      int g2;
      mul = longint'(1) << (12 + k);
      xin = floor_div10(2 * xc * mul + 5);
      yin = floor_div10(2 * yc * mul + 5);
      s = asr64((xin + yin) * 23988, 16);
      i = asr64(xin + s, 16);
      j = asr64(yin + s, 16);
      t = (i + j) * 13849;
      x0 = xin - (i * 65536 - t);
      y0 = yin - (j * 65536 - t);
      i1 = (x0 > y0) ? 1 : 0;
      j1 = 1 - i1;
      x1 = x0 - i1 * 65536 + 13849;
      y1 = y0 - j1 * 65536 + 13849;
      x2 = x0 - 65536 + 27698;
      y2 = y0 - 65536 + 27698;
      ii = i & 255;
      jj = j & 255;
      g0 = hashed_grad(ii + PermTable[jj]);
      g1 = hashed_grad(ii + i1 + PermTable[(jj + j1) & 255]);
      g2 = hashed_grad(ii + 1 + PermTable[(jj + 1) & 255]);
      sum = falloff_term(g0, x0, y0) + falloff_term(g1, x1, y1)
          + falloff_term(g2, x2, y2);
      return asr64(asr64(sum * 70, 16), k + 1);
   endfunction

   function automatic logic signed [15:0] fractal_noise(sample_type smp, logic [3:0] oct);
      int n;
      longint acc;
      longint r;
      n = (oct == 0) ? 1 : ((oct > 8) ? 8 : int'(oct));
      acc = 0;
      for (int k = 0; k < n; k++) acc += octave_noise(smp.x, smp.y, k);
      r = asr64(acc + 65536, 17);
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return 16'(r);
   endfunction

   // Driver: bursts of beats separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_beat.valid <= 1'b0;
      end else begin
         if (req_beat.valid && req_beat.ready) begin
            expected_noise.push_back(fractal_noise({req_beat.x_coord, req_beat.y_coord},
                                                   octave_setting));
            void'(pending_samples.pop_front());
         end
         if (!(req_beat.valid && !req_beat.ready)) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_beat.valid <= 1'b0;
            end else if (burst_left == 0 && pending_samples.size() != 0) begin
               burst_left <= $urandom_range(1, 30);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
               req_beat.valid <= 1'b0;
            end else begin
               // The accepted sample was popped above, so the front is the next one.
               if (!hold_sender && pending_samples.size() > 0 && burst_left > 0) begin
                  req_beat.valid <= 1'b1;
                  req_beat.x_coord <= pending_samples[0].x;
                  req_beat.y_coord <= pending_samples[0].y;
                  burst_left <= burst_left - 1;
               end else begin
                  req_beat.valid <= 1'b0;
               end
            end
         end
      end
   end

   // Monitor and response-side stall pattern.
   always @(posedge clock) begin
      if (reset) begin
         rsp_beat.ready <= 1'b0;
      end else begin
         stall_phase <= (stall_phase + 1) % 97;
         rsp_beat.ready <= (stall_phase < 40) ? 1'b1 : ($urandom_range(0, 3) != 0);
         if (rsp_beat.valid && rsp_beat.ready) begin
            if (expected_noise.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected noise beat %0d", rsp_beat.noise_value);
            end else begin
               if (rsp_beat.noise_value !== expected_noise[0]) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("noise mismatch: expected %0d, got %0d",
                              expected_noise[0], rsp_beat.noise_value);
               end
               void'(expected_noise.pop_front());
            end
         end
         if ((req_beat.valid && req_beat.ready) || (rsp_beat.valid && rsp_beat.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WatchdogLimit) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   task automatic queue_sample(int x, int y);
      sample_type smp;
      smp.x = 16'(x);
      smp.y = 16'(y);
      pending_samples.push_back(smp);
   endtask

   task automatic drain_pipeline();
      while (pending_samples.size() != 0 || req_beat.valid || expected_noise.size() != 0)
         @(posedge clock);
      repeat (Latency + 5) @(posedge clock);
   endtask

   task automatic set_octaves(logic [3:0] value);
      drain_pipeline();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      octave_setting = value;
   endtask

   task automatic queue_random_samples(int count);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 3) == 0)
            queue_sample($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768);
         else
            queue_sample($urandom_range(0, 400) - 200, $urandom_range(0, 400) - 200);
      end
   endtask

   initial begin
      req_beat.valid = 1'b0;
      req_beat.x_coord = '0;
      req_beat.y_coord = '0;
      rsp_beat.ready = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      // Directed: corners of the coordinate range, origin, and cell edges.
      queue_sample(0, 0);
      queue_sample(32767, 32767);
      queue_sample(-32768, -32768);
      queue_sample(32767, -32768);
      queue_sample(-32768, 32767);
      queue_sample(-1, -1);
      queue_sample(1, 0);
      queue_sample(0, 1);
      queue_sample(80, 80);
      queue_sample(-80, 40);
      queue_sample(21845, -10922);
      queue_sample(40, 39);
      drain_pipeline();
      // Zero acts as one octave; values above the maximum saturate.
      set_octaves(4'd0);
      queue_sample(0, 0);
      queue_sample(32767, -32768);
      queue_sample(-123, 456);
      set_octaves(4'd15);
      queue_sample(-32768, 32767);
      queue_sample(777, -777);
      set_octaves(4'd1);
      queue_random_samples(150);
      // Let the pipeline empty completely mid-run before more traffic.
      repeat (20) @(posedge clock);
      hold_sender = 1'b1;
      @(posedge clock);
      while (req_beat.valid || expected_noise.size() != 0)
         @(posedge clock);
      hold_sender = 1'b0;
      set_octaves(4'd4);
      queue_random_samples(150);
      set_octaves(4'd8);
      queue_random_samples(150);
      set_octaves(4'd9);
      queue_random_samples(150);
      drain_pipeline();
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
